@@ src/shr_pkg.sv @@
// Shared types, field layout and codes for the scheduled hysteresis relay.
// Used by shr_ctrl, shr_dp and scheduled_hysteresis_relay; depends on nothing.
package shr_pkg;

    localparam int MAX_PERIODS_DEF = 8;
    localparam int RESULT_LIMIT    = 24;
    localparam int EMIT_W          = $clog2(RESULT_LIMIT + 1);

    localparam int POWER_W  = 20;
    localparam int HOUR_W   = 12;
    localparam int SEC_W    = 32;
    localparam int SLOT_W   = 3;
    localparam int KIND_W   = 3;
    localparam int THR_W    = 16;
    localparam int REPEAT_W = 15;
    localparam int COUNT_W  = 4;
    localparam int CMDO_W   = 2;

    // Input beat layout, lowest bit first.
    localparam int POWER_LSB = 0;
    localparam int HOUR_LSB  = POWER_LSB + POWER_W;
    localparam int NOW_LSB   = HOUR_LSB + HOUR_W;
    localparam int SLOT_LSB  = NOW_LSB + SEC_W;
    localparam int KIND_LSB  = SLOT_LSB + SLOT_W;
    localparam int END_LSB   = KIND_LSB + KIND_W;
    localparam int LOW_LSB   = END_LSB + HOUR_W;
    localparam int HIGH_LSB  = LOW_LSB + THR_W;
    localparam int S_USED_W  = HIGH_LSB + THR_W;
    localparam int S_TDATA_W = ((S_USED_W + 7) / 8) * 8;
    localparam int M_TDATA_W = 8;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = REPEAT_W;
    localparam logic [REPEAT_W-1:0] REPEAT_MAX = REPEAT_W'(32000);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ENABLED   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REMOTE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ON_LEVEL  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_LEVEL = 3'd5;

    // Period kinds.
    localparam logic [KIND_W-1:0] KIND_OFF  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_ON   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_HYST = 3'd3;

    // Result commands.
    localparam logic [CMDO_W-1:0] CMD_PIN_ON  = 2'd0;
    localparam logic [CMDO_W-1:0] CMD_PIN_OFF = 2'd1;
    localparam logic [CMDO_W-1:0] CMD_REM_ON  = 2'd2;
    localparam logic [CMDO_W-1:0] CMD_REM_OFF = 2'd3;

    // Action selectors from controller to datapath.
    localparam logic [1:0] ACT_ON  = 2'd0;
    localparam logic [1:0] ACT_OFF = 2'd1;
    localparam logic [1:0] ACT_REP = 2'd2;

    typedef struct packed {
        logic       load;
        logic       start;
        logic       chk;
        logic       step;
        logic       act;
        logic [1:0] act_sel;
        logic       flush;
    } shr_cmd_t;

    typedef struct packed {
        logic enabled;
        logic done;
        logic match;
        logic fire_on;
        logic fire_off;
        logic fire_rep;
        logic emit_stall;
        logic pend_valid;
        logic out_free;
    } shr_stat_t;

endpackage

@@ src/shr_ctrl.sv @@
// Sequencer for the scheduled hysteresis relay: accepts beats and walks periods.
// Depends on shr_pkg; drives shr_dp through shr_cmd_t and reads shr_stat_t.
module shr_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic              s_tuser,
    input  shr_pkg::shr_stat_t stat,
    output shr_pkg::shr_cmd_t  cmd
);
    import shr_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_ON    = 3'd2;
    localparam logic [2:0] ST_OFF   = 3'd3;
    localparam logic [2:0] ST_REP   = 3'd4;
    localparam logic [2:0] ST_FLUSH = 3'd5;

    logic [2:0] state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.act_sel = ACT_ON;
        s_tready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (s_tuser) begin
                        cmd.load = 1'b1;
                    end else if (stat.enabled) begin
                        cmd.start  = 1'b1;
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                if (stat.done) begin
                    state_next = ST_FLUSH;
                end else begin
                    cmd.chk = 1'b1;
                    if (stat.match) begin
                        state_next = ST_ON;
                    end else begin
                        cmd.step = 1'b1;
                    end
                end
            end
            ST_ON: begin
                cmd.act_sel = ACT_ON;
                if (!(stat.fire_on && stat.emit_stall)) begin
                    cmd.act    = stat.fire_on;
                    state_next = ST_OFF;
                end
            end
            ST_OFF: begin
                cmd.act_sel = ACT_OFF;
                if (!(stat.fire_off && stat.emit_stall)) begin
                    cmd.act    = stat.fire_off;
                    state_next = ST_REP;
                end
            end
            ST_REP: begin
                cmd.act_sel = ACT_REP;
                if (!(stat.fire_rep && stat.emit_stall)) begin
                    cmd.act    = stat.fire_rep;
                    cmd.step   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_FLUSH: begin
                if (!stat.pend_valid) begin
                    state_next = ST_IDLE;
                end else if (stat.out_free) begin
                    cmd.flush  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Handing over the final result of an item ends the walk and returns to idle.
    a_flush_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.flush |=> state_reg == ST_IDLE)
        else $error("flush did not return to idle");

    // Table writes only happen between evaluations.
    a_load_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |-> state_reg == ST_IDLE && !cmd.start)
        else $error("table write during evaluation");

    a_start_walks: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.start |=> state_reg == ST_CHECK)
        else $error("evaluate beat did not start a walk");

endmodule

@@ src/shr_dp.sv @@
// Datapath of the scheduled hysteresis relay: registers, period table,
// relay state, threshold compares and the result hold/output stages. Uses shr_pkg.
module shr_dp #(
    parameter int MAX_PERIODS = shr_pkg::MAX_PERIODS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  shr_pkg::shr_cmd_t                 cmd,
    output shr_pkg::shr_stat_t                stat,
    input  logic [shr_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic                              cfg_valid,
    input  logic [shr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [shr_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              m_tready,
    output logic                              m_tvalid,
    output logic [shr_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                              m_tlast
);
    import shr_pkg::*;

    localparam int IDX_W = (MAX_PERIODS > 1) ? $clog2(MAX_PERIODS) : 1;
    localparam int CNT_W = $clog2(MAX_PERIODS + 1);
    localparam int CMP_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
    localparam int SCMP_W = CNT_W + SLOT_W;

    // Configuration registers.
    logic                enabled_reg, remote_reg, on_level_reg, off_level_reg;
    logic [REPEAT_W-1:0] repeat_reg;
    logic [COUNT_W-1:0]  count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enabled_reg   <= 1'b0;
            remote_reg    <= 1'b0;
            repeat_reg    <= '0;
            count_reg     <= '0;
            on_level_reg  <= 1'b1;
            off_level_reg <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_ENABLED:   enabled_reg   <= cfg_data[0];
                REG_REMOTE:    remote_reg    <= cfg_data[0];
                REG_REPEAT:    repeat_reg    <= (cfg_data > REPEAT_MAX) ? REPEAT_MAX : cfg_data;
                REG_COUNT:     count_reg     <= cfg_data[COUNT_W-1:0];
                REG_ON_LEVEL:  on_level_reg  <= cfg_data[0];
                REG_OFF_LEVEL: off_level_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Input beat fields.
    logic signed [POWER_W-1:0] in_power;
    logic [HOUR_W-1:0]         in_hour, in_end;
    logic [SEC_W-1:0]          in_now;
    logic [SLOT_W-1:0]         in_slot;
    logic [KIND_W-1:0]         in_kind;
    logic signed [THR_W-1:0]   in_low, in_high;

    assign in_power = s_tdata[POWER_LSB +: POWER_W];
    assign in_hour  = s_tdata[HOUR_LSB +: HOUR_W];
    assign in_now   = s_tdata[NOW_LSB +: SEC_W];
    assign in_slot  = s_tdata[SLOT_LSB +: SLOT_W];
    assign in_kind  = s_tdata[KIND_LSB +: KIND_W];
    assign in_end   = s_tdata[END_LSB +: HOUR_W];
    assign in_low   = s_tdata[LOW_LSB +: THR_W];
    assign in_high  = s_tdata[HIGH_LSB +: THR_W];

    // Period table; an entry never written since reset reads as all zeros.
    logic [MAX_PERIODS-1:0]  tbl_valid_reg;
    logic [KIND_W-1:0]       tbl_kind [MAX_PERIODS];
    logic [HOUR_W-1:0]       tbl_end  [MAX_PERIODS];
    logic signed [THR_W-1:0] tbl_low  [MAX_PERIODS];
    logic signed [THR_W-1:0] tbl_high [MAX_PERIODS];

    logic [SCMP_W-1:0] slot_wide;
    logic [IDX_W-1:0]  wr_idx;
    logic              slot_ok;

    assign slot_wide = SCMP_W'(in_slot);
    assign wr_idx    = slot_wide[IDX_W-1:0];
    assign slot_ok   = slot_wide < SCMP_W'(MAX_PERIODS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tbl_valid_reg <= '0;
        end else if (cmd.load && slot_ok) begin
            tbl_valid_reg[wr_idx] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load && slot_ok) begin
            tbl_kind[wr_idx] <= in_kind;
            tbl_end[wr_idx]  <= in_end;
            tbl_low[wr_idx]  <= in_low;
            tbl_high[wr_idx] <= in_high;
        end
    end

    // Walk state and latched evaluate fields.
    logic [CNT_W-1:0]          idx_reg;
    logic [HOUR_W-1:0]         prev_end_reg;
    logic signed [POWER_W-1:0] power_reg;
    logic [HOUR_W-1:0]         hour_reg;
    logic [SEC_W-1:0]          now_reg;

    logic [IDX_W-1:0]          rd_idx;
    logic                      rd_valid;
    logic [KIND_W-1:0]         cur_kind;
    logic [HOUR_W-1:0]         cur_end;
    logic signed [THR_W-1:0]   cur_low, cur_high;
    logic signed [POWER_W-1:0] low_scaled, high_scaled;

    assign rd_idx      = idx_reg[IDX_W-1:0];
    assign rd_valid    = tbl_valid_reg[rd_idx];
    assign cur_kind    = rd_valid ? tbl_kind[rd_idx] : '0;
    assign cur_end     = rd_valid ? tbl_end[rd_idx]  : '0;
    assign cur_low     = rd_valid ? tbl_low[rd_idx]  : '0;
    assign cur_high    = rd_valid ? tbl_high[rd_idx] : '0;
    assign low_scaled  = {cur_low, 4'b0000};
    assign high_scaled = {cur_high, 4'b0000};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
        end else if (cmd.start) begin
            idx_reg <= '0;
        end else if (cmd.step) begin
            idx_reg <= idx_reg + CNT_W'(1);
        end
    end

    // Period flags captured while checking; consumed by the action steps.
    logic k_on_reg, k_off_reg, k_hyst_reg, below_reg, above_reg;

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            prev_end_reg <= '0;
            power_reg    <= in_power;
            hour_reg     <= in_hour;
            now_reg      <= in_now;
        end else if (cmd.chk) begin
            prev_end_reg <= cur_end;
        end
        if (cmd.chk) begin
            k_on_reg   <= cur_kind == KIND_ON;
            k_off_reg  <= cur_kind == KIND_OFF;
            k_hyst_reg <= cur_kind == KIND_HYST;
            below_reg  <= power_reg < low_scaled;
            above_reg  <= power_reg > high_scaled;
        end
    end

    // Relay state.
    logic             relay_on_reg;
    logic [SEC_W-1:0] last_action_reg;
    logic [SEC_W-1:0] elapsed;
    logic             rep_nz, elapsed_gt;

    assign rep_nz     = repeat_reg != '0;
    assign elapsed    = now_reg - last_action_reg;
    assign elapsed_gt = elapsed > SEC_W'(repeat_reg);

    // Result hold stage and output register.
    logic [EMIT_W-1:0] emit_cnt_reg;
    logic              limit_hit;
    logic              pend_valid_reg;
    logic [CMDO_W-1:0] pend_cmd_reg;
    logic              pend_level_reg;
    logic              m_tvalid_reg, m_tlast_reg, m_level_reg;
    logic [CMDO_W-1:0] m_cmd_reg;
    logic              out_free, emit, push;
    logic [CMDO_W-1:0] new_cmd;
    logic              new_level;

    assign limit_hit = emit_cnt_reg == EMIT_W'(RESULT_LIMIT);
    assign out_free  = !m_tvalid_reg || m_tready;
    assign emit      = cmd.act && !limit_hit;
    assign push      = (emit || cmd.flush) && pend_valid_reg;

    always_comb begin
        case (cmd.act_sel)
            ACT_ON: begin
                new_cmd   = remote_reg ? CMD_REM_ON : CMD_PIN_ON;
                new_level = remote_reg ? 1'b0 : on_level_reg;
            end
            ACT_OFF: begin
                new_cmd   = remote_reg ? CMD_REM_OFF : CMD_PIN_OFF;
                new_level = remote_reg ? 1'b0 : off_level_reg;
            end
            default: begin
                new_cmd   = relay_on_reg ? CMD_REM_ON : CMD_REM_OFF;
                new_level = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            relay_on_reg    <= 1'b0;
            last_action_reg <= '0;
        end else if (cmd.act) begin
            if (cmd.act_sel == ACT_ON) begin
                relay_on_reg <= 1'b1;
            end else if (cmd.act_sel == ACT_OFF) begin
                relay_on_reg <= 1'b0;
            end
            if (remote_reg) begin
                last_action_reg <= now_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            emit_cnt_reg   <= '0;
            pend_valid_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (cmd.start) begin
                emit_cnt_reg <= '0;
            end else if (emit) begin
                emit_cnt_reg <= emit_cnt_reg + EMIT_W'(1);
            end
            if (emit) begin
                pend_valid_reg <= 1'b1;
            end else if (cmd.flush) begin
                pend_valid_reg <= 1'b0;
            end
            if (push) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            pend_cmd_reg   <= new_cmd;
            pend_level_reg <= new_level;
        end
        if (push) begin
            m_cmd_reg   <= pend_cmd_reg;
            m_level_reg <= pend_level_reg;
            m_tlast_reg <= cmd.flush;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tdata  = {{(M_TDATA_W - CMDO_W - 1){1'b0}}, m_level_reg, m_cmd_reg};

    // Status back to the controller.
    always_comb begin
        stat.enabled    = enabled_reg;
        stat.done       = (CMP_W'(idx_reg) >= CMP_W'(count_reg))
                          || (idx_reg == CNT_W'(MAX_PERIODS));
        stat.match      = (hour_reg >= prev_end_reg) && (hour_reg <= cur_end);
        stat.fire_on    = (k_on_reg || (k_hyst_reg && below_reg))
                          && (!remote_reg || (!relay_on_reg && rep_nz));
        stat.fire_off   = (k_off_reg || (k_hyst_reg && above_reg))
                          && (!remote_reg || relay_on_reg);
        stat.fire_rep   = remote_reg && k_hyst_reg && rep_nz && elapsed_gt;
        stat.emit_stall = pend_valid_reg && !out_free && !limit_hit;
        stat.pend_valid = pend_valid_reg;
        stat.out_free   = out_free;
    end

    // A held result may only move out when the output register is free.
    a_push_free: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> out_free)
        else $error("output beat overwritten before it was taken");

    a_emit_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_cnt_reg <= EMIT_W'(RESULT_LIMIT))
        else $error("result count beyond limit");

    a_on_sets: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.act && cmd.act_sel == ACT_ON) |=> relay_on_reg)
        else $error("switch-on did not set relay state");

    a_flush_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.flush && pend_valid_reg) |=> (m_tvalid_reg && m_tlast_reg && !pend_valid_reg))
        else $error("final result not marked last");

endmodule

@@ src/scheduled_hysteresis_relay.sv @@
// Top level of the scheduled hysteresis relay controller.
// Joins shr_ctrl and shr_dp; depends on shr_pkg.
//
// Channel  Dir  Handshake             Contents
// s_       in   s_tvalid/s_tready     tuser: cmd; tdata: power, hour, now_sec, slot,
//                                     slot_type, slot_end, slot_low, slot_high
// m_       out  m_tvalid/m_tready     tdata: command, level; tlast: last
// cfg_     in   cfg_valid/cfg_ready   cfg_index selects the register, cfg_data value
//
// A load beat is accepted in idle and writes its table entry. An evaluate beat is
// accepted in idle, then each walked period is checked; a period whose range holds
// the hour also runs the switch-on, switch-off and repeat steps. Once the walk is
// found done the final result is handed over; no new beat is taken until then.
// Reset clears the period table valid bits and all control state at once.
// A stalled result beat holds further results in one hold register; the walk waits
// only when that register and the output register are both full.
module scheduled_hysteresis_relay #(
    parameter int MAX_PERIODS = shr_pkg::MAX_PERIODS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Input beat.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // tdata from bit 0: power[19:0], hour[31:20], now_sec[63:32], slot[66:64],
    // slot_type[69:67], slot_end[81:70], slot_low[97:82], slot_high[113:98], zeros.
    input  logic [shr_pkg::S_TDATA_W-1:0]  s_tdata,
    // tuser: cmd (0 evaluate, 1 load).
    input  logic                           s_tuser,
    // Result beat.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // tdata from bit 0: command[1:0], level[2], zeros.
    output logic [shr_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                           m_tlast,
    // Configuration writes.
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [shr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [shr_pkg::CFG_DATA_W-1:0] cfg_data
);
    import shr_pkg::*;

    shr_cmd_t  cmd;
    shr_stat_t stat;

    assign cfg_ready = 1'b1;

    shr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .stat     (stat),
        .cmd      (cmd)
    );

    shr_dp #(
        .MAX_PERIODS (MAX_PERIODS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking bench for scheduled_hysteresis_relay: predicts relay orders per input beat
// and compares each result beat in order. Depends on shr_pkg and the RTL top level.
module testbench;
    import shr_pkg::*;

    localparam int PERIODS       = MAX_PERIODS_DEF;
    localparam int SETTLE_CYCLES = 64;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_BEATS   = 24;

    // Kinds that take no relay action; the package names only the acting ones.
    localparam logic [KIND_W-1:0] KIND_NONE  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_TRIAC = 3'd4;

    typedef struct {
        logic                     cmd;
        logic signed [POWER_W-1:0] power;
        logic [HOUR_W-1:0]        hour;
        logic [SEC_W-1:0]         now_sec;
        logic [SLOT_W-1:0]        slot;
        logic [KIND_W-1:0]        kind;
        logic [HOUR_W-1:0]        p_end;
        logic signed [THR_W-1:0]  p_low;
        logic signed [THR_W-1:0]  p_high;
    } relay_beat_t;

    typedef struct {
        logic [CMDO_W-1:0] command;
        logic              level;
        logic              last;
    } relay_order_t;

    typedef struct {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] value;
    } reg_write_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    scheduled_hysteresis_relay #(.MAX_PERIODS(PERIODS)) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Predicted controller state and register copies.
    logic                   ref_enabled = 1'b0;
    logic                   ref_remote = 1'b0;
    logic [REPEAT_W-1:0]    ref_repeat = '0;
    logic [COUNT_W-1:0]     ref_count = '0;
    logic                   ref_on_level = 1'b1;
    logic                   ref_off_level = 1'b0;
    logic                   relay_is_on = 1'b0;
    logic [SEC_W-1:0]       last_order_sec = '0;
    logic [KIND_W-1:0]      tab_kind [PERIODS];
    logic [HOUR_W-1:0]      tab_end  [PERIODS];
    logic signed [THR_W-1:0] tab_low [PERIODS];
    logic signed [THR_W-1:0] tab_high [PERIODS];

    relay_beat_t  beats_to_send [$];
    relay_order_t expected_orders [$];
    reg_write_t   reg_writes [$];

    // Schedule of the current phase, used only to aim the stimulus.
    int sched_n;
    int sched_end  [PERIODS];
    int sched_low  [PERIODS];
    int sched_high [PERIODS];

    bit quiet_tail = 1'b0;
    int mismatches = 0;
    int beats_queued = 0;
    int beats_accepted = 0;
    int orders_seen = 0;
    int loads_sent = 0;
    int evals_sent = 0;
    int settings_used = 0;

    function automatic void apply_reg(input reg_write_t w);
        case (w.index)
            REG_ENABLED:   ref_enabled = w.value[0];
            REG_REMOTE:    ref_remote = w.value[0];
            REG_REPEAT:    ref_repeat = (w.value > REPEAT_MAX) ? REPEAT_MAX : w.value;
            REG_COUNT:     ref_count = w.value[COUNT_W-1:0];
            REG_ON_LEVEL:  ref_on_level = w.value[0];
            REG_OFF_LEVEL: ref_off_level = w.value[0];
            default: ;
        endcase
    endfunction

    // Works out the orders one accepted beat causes and queues them.
    function automatic void predict_relay_orders(input relay_beat_t b);
        int walk;
        int pw;
        int lo_w;
        int hi_w;
        logic [HOUR_W-1:0] start;
        logic [SEC_W-1:0] elapsed;
        logic below;
        logic above;
        logic want_on;
        logic want_off;
        relay_order_t orders [$];
        if (b.cmd) begin
            if (int'(b.slot) < PERIODS) begin
                tab_kind[b.slot] = b.kind;
                tab_end[b.slot]  = b.p_end;
                tab_low[b.slot]  = b.p_low;
                tab_high[b.slot] = b.p_high;
            end
            return;
        end
        if (!ref_enabled) return;
        walk = (int'(ref_count) > PERIODS) ? PERIODS : int'(ref_count);
        pw = b.power;
        for (int i = 0; i < walk; i++) begin
            start = (i == 0) ? '0 : tab_end[i-1];
            if (b.hour < start || b.hour > tab_end[i]) continue;
            lo_w = tab_low[i];
            hi_w = tab_high[i];
            below = pw < lo_w * 16;
            above = pw > hi_w * 16;
            want_on  = (tab_kind[i] == KIND_ON)  || (tab_kind[i] == KIND_HYST && below);
            want_off = (tab_kind[i] == KIND_OFF) || (tab_kind[i] == KIND_HYST && above);
            if (!ref_remote) begin
                if (want_on) begin
                    orders.push_back('{CMD_PIN_ON, ref_on_level, 1'b0});
                    relay_is_on = 1'b1;
                end
                if (want_off) begin
                    orders.push_back('{CMD_PIN_OFF, ref_off_level, 1'b0});
                    relay_is_on = 1'b0;
                end
            end else begin
                if (want_on && !relay_is_on && ref_repeat != '0) begin
                    orders.push_back('{CMD_REM_ON, 1'b0, 1'b0});
                    relay_is_on = 1'b1;
                    last_order_sec = b.now_sec;
                end
                if (want_off && relay_is_on) begin
                    orders.push_back('{CMD_REM_OFF, 1'b0, 1'b0});
                    relay_is_on = 1'b0;
                    last_order_sec = b.now_sec;
                end
                // The elapsed time is taken after any switch in this same period.
                elapsed = b.now_sec - last_order_sec;
                if (tab_kind[i] == KIND_HYST && ref_repeat != '0 &&
                    elapsed > SEC_W'(ref_repeat)) begin
                    orders.push_back('{relay_is_on ? CMD_REM_ON : CMD_REM_OFF, 1'b0, 1'b0});
                    last_order_sec = b.now_sec;
                end
            end
        end
        while (orders.size() > RESULT_LIMIT) void'(orders.pop_back());
        if (orders.size() > 0) orders[orders.size()-1].last = 1'b1;
        foreach (orders[k]) expected_orders.push_back(orders[k]);
    endfunction

    // Input side: one beat on the bus at a time, random gaps between beats.
    relay_beat_t beat_on_bus;
    int          send_gap = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_relay_orders(beat_on_bus);
                beats_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (beats_to_send.size() > 0 &&
                             (quiet_tail || $urandom_range(0, 3) != 0)) begin
                    beat_on_bus = beats_to_send.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= beat_on_bus.cmd;
                    s_tdata  <= S_TDATA_W'({beat_on_bus.p_high, beat_on_bus.p_low,
                                            beat_on_bus.p_end, beat_on_bus.kind,
                                            beat_on_bus.slot, beat_on_bus.now_sec,
                                            beat_on_bus.hour, beat_on_bus.power});
                end else begin
                    s_tvalid <= 1'b0;
                    if (beats_to_send.size() > 0) send_gap = $urandom_range(0, 9);
                end
            end
        end
    end

    // Result side: check every result beat in order, stall in random bursts.
    relay_order_t want;
    int           hold_left = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                orders_seen++;
                if (expected_orders.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result beat, command %0d level %0d last %0d",
                             $time, m_tdata[1:0], m_tdata[2], m_tlast);
                end else begin
                    want = expected_orders.pop_front();
                    if (m_tdata[1:0] !== want.command) begin
                        mismatches++;
                        $display("%0t: command expected %0d actual %0d",
                                 $time, want.command, m_tdata[1:0]);
                    end
                    if (m_tdata[2] !== want.level) begin
                        mismatches++;
                        $display("%0t: level expected %0d actual %0d",
                                 $time, want.level, m_tdata[2]);
                    end
                    if (m_tlast !== want.last) begin
                        mismatches++;
                        $display("%0t: last expected %0d actual %0d",
                                 $time, want.last, m_tlast);
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
                hold_left = $urandom_range(0, 9);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic push_load(input int slot_v, input int kind_v, input int end_v,
                             input int lo_v, input int hi_v);
        relay_beat_t b;
        b.cmd     = 1'b1;
        b.power   = POWER_W'($urandom);
        b.hour    = HOUR_W'($urandom);
        b.now_sec = $urandom;
        b.slot    = SLOT_W'(slot_v);
        b.kind    = KIND_W'(kind_v);
        b.p_end   = HOUR_W'(end_v);
        b.p_low   = THR_W'(lo_v);
        b.p_high  = THR_W'(hi_v);
        beats_to_send.push_back(b);
        beats_queued++;
        loads_sent++;
    endtask

    task automatic push_eval(input int power_v, input int hour_v, input logic [SEC_W-1:0] now_v);
        relay_beat_t b;
        b.cmd     = 1'b0;
        b.power   = POWER_W'(power_v);
        b.hour    = HOUR_W'(hour_v);
        b.now_sec = now_v;
        b.slot    = SLOT_W'($urandom);
        b.kind    = KIND_W'($urandom);
        b.p_end   = HOUR_W'($urandom);
        b.p_low   = THR_W'($urandom);
        b.p_high  = THR_W'($urandom);
        beats_to_send.push_back(b);
        beats_queued++;
        evals_sent++;
    endtask

    // Called on a clock edge; cfg_valid stays high across back-to-back writes.
    task automatic write_registers();
        reg_write_t w;
        settings_used++;
        while (reg_writes.size() > 0) begin
            w = reg_writes.pop_front();
            cfg_valid <= 1'b1;
            cfg_index <= w.index;
            cfg_data  <= w.value;
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            apply_reg(w);
        end
        cfg_valid <= 1'b0;
    endtask

    // Waits until every beat is in and every order is out, then lets an evaluate
    // that produces nothing finish its walk.
    task automatic drain_phase();
        while (beats_accepted != beats_queued || expected_orders.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic run_random_phase(input int beats);
        int walk;
        int acc;
        int pick;
        int roll;
        int thr;
        int hr;
        int kinds_pool [8];
        logic [CFG_DATA_W-1:0] rnd;
        logic [SEC_W-1:0] clock_sec;
        kinds_pool = '{KIND_OFF, KIND_ON, KIND_HYST, KIND_HYST, KIND_HYST,
                       KIND_NONE, KIND_TRIAC, KIND_HYST};

        rnd = CFG_DATA_W'($urandom);
        rnd[0] = ($urandom_range(0, 9) != 0);
        reg_writes.push_back('{REG_ENABLED, rnd});
        reg_writes.push_back('{REG_REMOTE, CFG_DATA_W'($urandom)});
        case ($urandom_range(0, 4))
            0:       rnd = '0;
            1:       rnd = CFG_DATA_W'($urandom_range(32001, 32767));
            2:       rnd = REPEAT_MAX;
            default: rnd = CFG_DATA_W'($urandom_range(1, 40));
        endcase
        reg_writes.push_back('{REG_REPEAT, rnd});
        rnd = CFG_DATA_W'($urandom);
        case ($urandom_range(0, 7))
            0:       rnd[COUNT_W-1:0] = '0;
            1:       rnd[COUNT_W-1:0] = COUNT_W'($urandom_range(9, 15));
            default: rnd[COUNT_W-1:0] = COUNT_W'($urandom_range(1, 8));
        endcase
        walk = (int'(rnd[COUNT_W-1:0]) > PERIODS) ? PERIODS : int'(rnd[COUNT_W-1:0]);
        reg_writes.push_back('{REG_COUNT, rnd});
        reg_writes.push_back('{REG_ON_LEVEL, CFG_DATA_W'($urandom)});
        reg_writes.push_back('{REG_OFF_LEVEL, CFG_DATA_W'($urandom)});
        write_registers();

        // A mostly well-formed schedule: ends usually rising through the day, half hysteresis.
        sched_n = (walk == 0) ? 2 : walk;
        acc = 0;
        for (int i = 0; i < sched_n; i++) begin
            acc = acc + $urandom_range(0, 4800 / sched_n);
            if (acc > 2400 || (i == sched_n - 1 && $urandom_range(0, 1) == 0)) acc = 2400;
            sched_end[i] = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4095) : acc;
            if ($urandom_range(0, 7) == 0) begin
                sched_low[i]  = $urandom_range(0, 65535) - 32768;
                sched_high[i] = $urandom_range(0, 65535) - 32768;
            end else begin
                sched_low[i]  = $urandom_range(0, 4000) - 2000;
                sched_high[i] = sched_low[i] + $urandom_range(0, 400) - 40;
            end
            push_load(i, kinds_pool[$urandom_range(0, 7)], sched_end[i],
                      sched_low[i], sched_high[i]);
        end

        clock_sec = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FF00 : $urandom;
        for (int n = 0; n < beats; n++) begin
            roll = $urandom_range(0, 19);
            if (roll == 0) begin
                push_load($urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(0, 4095),
                          $urandom_range(0, 65535), $urandom_range(0, 65535));
            end else if (roll == 1) begin
                push_eval($urandom, $urandom, $urandom);
            end else begin
                if ($urandom_range(0, 9) == 0) clock_sec += $urandom_range(20000, 40000);
                else clock_sec += $urandom_range(0, 40);
                pick = $urandom_range(0, sched_n - 1);
                case ($urandom_range(0, 5))
                    0, 1:    hr = sched_end[pick];
                    2, 3:    hr = $urandom_range(pick == 0 ? 0 : sched_end[pick-1],
                                                 sched_end[pick]);
                    4:       hr = $urandom_range(0, 2400);
                    default: hr = $urandom_range(2401, 4095);
                endcase
                thr = $urandom_range(0, 1) ? sched_low[pick] : sched_high[pick];
                push_eval(thr * 16 + $urandom_range(0, 64) - 32, hr, clock_sec);
            end
        end
        drain_phase();
    endtask

    initial begin
        for (int i = 0; i < PERIODS; i++) begin
            tab_kind[i] = '0;
            tab_end[i]  = '0;
            tab_low[i]  = '0;
            tab_high[i] = '0;
        end
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Disabled controller: a full table walk must stay silent.
        push_load(0, KIND_ON, 2400, -32768, 32767);
        push_load(7, 7, 4095, 32767, -32768);
        drain_phase();
        reg_writes.push_back('{REG_COUNT, CFG_DATA_W'(8)});
        write_registers();
        push_eval(0, 2400, 0);
        drain_phase();

        // Local mode with inverted pin levels, power extremes and boundary hours.
        reg_writes.push_back('{REG_ENABLED, CFG_DATA_W'(1)});
        reg_writes.push_back('{REG_REMOTE, CFG_DATA_W'(0)});
        reg_writes.push_back('{REG_REPEAT, CFG_DATA_W'(0)});
        reg_writes.push_back('{REG_COUNT, CFG_DATA_W'(4)});
        reg_writes.push_back('{REG_ON_LEVEL, CFG_DATA_W'(0)});
        reg_writes.push_back('{REG_OFF_LEVEL, CFG_DATA_W'(1)});
        write_registers();
        push_load(0, KIND_HYST, 1000, 10, 20);
        push_load(1, KIND_ON, 1500, 0, 0);
        push_load(2, KIND_OFF, 2400, 0, 0);
        push_load(3, KIND_TRIAC, 2400, 0, 0);
        push_eval(-524288, 0, 0);
        push_eval(524287, 500, 1);
        push_eval(160, 1000, 2);
        push_eval(0, 1500, 3);
        push_eval(0, 2400, 4);
        push_eval(0, 4095, 5);
        // Low threshold above the high one: both tests fire in one period.
        push_load(0, KIND_HYST, 1000, 100, -100);
        push_eval(0, 700, 6);
        drain_phase();

        // Remote mode, saturated repeat, count beyond the table, stamp wrap.
        reg_writes.push_back('{REG_REMOTE, CFG_DATA_W'(1)});
        reg_writes.push_back('{REG_REPEAT, CFG_DATA_W'(32767)});
        reg_writes.push_back('{REG_COUNT, CFG_DATA_W'(15)});
        reg_writes.push_back('{REG_ON_LEVEL, CFG_DATA_W'(1)});
        reg_writes.push_back('{REG_OFF_LEVEL, CFG_DATA_W'(0)});
        write_registers();
        push_load(4, KIND_NONE, 2400, 0, 0);
        push_load(5, 5, 2400, 0, 0);
        push_load(6, 7, 2400, 0, 0);
        push_load(7, KIND_HYST, 2400, 32767, -32768);
        push_eval(0, 700, 0);
        push_eval(0, 700, 40000);
        push_eval(0, 2400, 32'hFFFF_FFFF);
        push_eval(0, 2400, 31000);
        drain_phase();

        // Zero repeat interval: no remote switch-on and no repeats.
        reg_writes.push_back('{REG_REPEAT, CFG_DATA_W'(0)});
        write_registers();
        push_eval(0, 700, 100);
        push_eval(-524288, 2400, 200);
        drain_phase();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            quiet_tail = (p >= RANDOM_PHASES - 2);
            run_random_phase(PHASE_BEATS);
        end

        $display("Sent %0d input beats (%0d loads, %0d evaluates) under %0d register settings.",
                 beats_accepted, loads_sent, evals_sent, settings_used);
        $display("Checked %0d result beats against the predicted relay orders.", orders_seen);
        if (expected_orders.size() != 0) begin
            mismatches++;
            $display("%0t: %0d expected results never arrived", $time, expected_orders.size());
        end
        if (mismatches == 0) $display("PASSED: all results match");
        else $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #4_000_000;
        $display("%0t: run did not complete in time", $time);
        $display("FAILED: results differ");
        $finish;
    end

endmodule

@@ filelist.f @@
src/shr_pkg.sv
src/shr_ctrl.sv
src/shr_dp.sv
src/scheduled_hysteresis_relay.sv
dv/testbench.sv
